// ----- rtl/hbit_pkg.sv -----
// ----------------------------------------------------------------------------
// Hitbox intersection test package
// Shared widths, shape codes and pipeline structs for the hitbox pair test.
// ----------------------------------------------------------------------------
package hbit_pkg;

    // Field and datapath widths
    localparam int COORD_W = 20;            // signed Q16.4 origin
    localparam int SIZE_W  = 16;            // unsigned Q12.4 size
    localparam int EDGE_W  = COORD_W + 1;   // origin plus size
    localparam int DIFF_W  = COORD_W + 2;   // origin minus far edge
    localparam int RAD_W   = SIZE_W + 1;    // sum of two radii
    localparam int DIST_W  = COORD_W;       // clamped distance magnitude
    localparam int SQ_W    = 2 * DIST_W;    // squared axis distance
    localparam int RSQ_W   = 2 * RAD_W;     // squared radius
    localparam int SUM_W   = SQ_W + 1;      // sum of two squares

    // Shape codes
    localparam logic SHAPE_RECT   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [EDGE_W-1:0]  t_edge;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic        [SIZE_W-1:0]  t_size;
    typedef logic        [RAD_W-1:0]   t_rad;
    typedef logic        [DIST_W-1:0]  t_dist;
    typedef logic        [SQ_W-1:0]    t_sq;
    typedef logic        [RSQ_W-1:0]   t_rsq;
    typedef logic        [SUM_W-1:0]   t_sum;

    // Control that travels with each beat
    typedef struct packed {
        logic valid;    // beat present in this stage
        logic is_rr;    // rectangle against rectangle
        logic rr_hit;   // overlap result for the rectangle pair
    } t_ctl;

    // Rectangle against circle geometry after edge setup
    typedef struct packed {
        t_coord rx;     // rectangle left
        t_coord ry;     // rectangle top
        t_edge  rright; // rectangle right
        t_edge  rbot;   // rectangle bottom
        t_coord cx;     // circle center x
        t_coord cy;     // circle center y
        t_rad   rad;    // circle radius
    } t_geo;

    // Clamped distances to the circle center
    typedef struct packed {
        t_dist dx;
        t_dist dy;
        t_rad  rad;
    } t_dst;

endpackage

// ----- rtl/hbit_prep.sv -----
// ----------------------------------------------------------------------------
// Hitbox edge setup stage
// Orders the pair as rectangle against circle, forms far edges and settles
// the rectangle pair overlap test.
// ----------------------------------------------------------------------------
module hbit_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_shape_a,
    input  hbit_pkg::t_coord     i_ax,
    input  hbit_pkg::t_coord     i_ay,
    input  hbit_pkg::t_size      i_a_width,
    input  hbit_pkg::t_size      i_a_height,
    input  hbit_pkg::t_size      i_a_radius,
    input  logic                 i_shape_b,
    input  hbit_pkg::t_coord     i_bx,
    input  hbit_pkg::t_coord     i_by,
    input  hbit_pkg::t_size      i_b_width,
    input  hbit_pkg::t_size      i_b_height,
    input  hbit_pkg::t_size      i_b_radius,
    output hbit_pkg::t_ctl       o_ctl,
    output hbit_pkg::t_geo       o_geo
);
    import hbit_pkg::*;

    t_ctl   r_ctl, n_ctl;
    t_geo   r_geo, n_geo;
    t_coord rx, ry;
    t_size  rw, rh;
    t_edge  ax_e, ay_e, bx_e, by_e;
    t_edge  a_right, a_bot, b_right, b_bot;

    // Rectangle pair overlap: touching edges count as a hit
    always_comb begin
        ax_e    = {i_ax[COORD_W-1], i_ax};
        ay_e    = {i_ay[COORD_W-1], i_ay};
        bx_e    = {i_bx[COORD_W-1], i_bx};
        by_e    = {i_by[COORD_W-1], i_by};
        a_right = ax_e + t_edge'({1'b0, i_a_width});
        a_bot   = ay_e + t_edge'({1'b0, i_a_height});
        b_right = bx_e + t_edge'({1'b0, i_b_width});
        b_bot   = by_e + t_edge'({1'b0, i_b_height});
    end

    // Pick the rectangle and the circle; a circle pair becomes a point
    // against a circle of the summed radius
    always_comb begin
        rx        = i_ax;
        ry        = i_ay;
        rw        = i_a_width;
        rh        = i_a_height;
        n_geo.cx  = i_bx;
        n_geo.cy  = i_by;
        n_geo.rad = t_rad'({1'b0, i_b_radius});
        if (i_shape_a == SHAPE_CIRCLE) begin
            if (i_shape_b == SHAPE_RECT) begin
                rx        = i_bx;
                ry        = i_by;
                rw        = i_b_width;
                rh        = i_b_height;
                n_geo.cx  = i_ax;
                n_geo.cy  = i_ay;
                n_geo.rad = t_rad'({1'b0, i_a_radius});
            end else begin
                rw        = '0;
                rh        = '0;
                n_geo.rad = t_rad'({1'b0, i_a_radius}) + t_rad'({1'b0, i_b_radius});
            end
        end
        n_geo.rx     = rx;
        n_geo.ry     = ry;
        n_geo.rright = t_edge'({rx[COORD_W-1], rx}) + t_edge'({1'b0, rw});
        n_geo.rbot   = t_edge'({ry[COORD_W-1], ry}) + t_edge'({1'b0, rh});

        n_ctl.valid  = i_valid;
        n_ctl.is_rr  = (i_shape_a == SHAPE_RECT) && (i_shape_b == SHAPE_RECT);
        n_ctl.rr_hit = !((ax_e > b_right) || (a_right < bx_e) ||
                         (ay_e > b_bot)   || (a_bot < by_e));
    end

    // Advance valid under reset, payload free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.is_rr  <= n_ctl.is_rr;
        r_ctl.rr_hit <= n_ctl.rr_hit;
        r_geo        <= n_geo;
    end

    assign o_ctl = r_ctl;
    assign o_geo = r_geo;

endmodule

// ----- rtl/hbit_clamp.sv -----
// ----------------------------------------------------------------------------
// Hitbox clamp stage
// Clamps the circle center to the rectangle and keeps the distance from
// the clamped point to the center on each axis.
// ----------------------------------------------------------------------------
module hbit_clamp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbit_pkg::t_ctl       i_ctl,
    input  hbit_pkg::t_geo       i_geo,
    output hbit_pkg::t_ctl       o_ctl,
    output hbit_pkg::t_dst       o_dst
);
    import hbit_pkg::*;

    t_ctl r_ctl;
    t_dst r_dst, n_dst;

    // Distance from center to the span [lo, hi], zero when inside
    function automatic t_dist span_dist(t_coord lo, t_edge hi, t_coord c);
        t_edge below;
        t_diff above;
        t_dist d;
        below = t_edge'({lo[COORD_W-1], lo}) - t_edge'({c[COORD_W-1], c});
        above = t_diff'({{2{c[COORD_W-1]}}, c}) - t_diff'({hi[EDGE_W-1], hi});
        d     = '0;
        if (!below[EDGE_W-1] && (below != '0)) begin
            d = below[DIST_W-1:0];
        end else if (!above[DIFF_W-1] && (above != '0)) begin
            d = above[DIST_W-1:0];
        end
        return d;
    endfunction

    // Clamp both axes
    always_comb begin
        n_dst.dx  = span_dist(i_geo.rx, i_geo.rright, i_geo.cx);
        n_dst.dy  = span_dist(i_geo.ry, i_geo.rbot, i_geo.cy);
        n_dst.rad = i_geo.rad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.is_rr  <= i_ctl.is_rr;
        r_ctl.rr_hit <= i_ctl.rr_hit;
        r_dst        <= n_dst;
    end

    assign o_ctl = r_ctl;
    assign o_dst = r_dst;

endmodule

// ----- rtl/hbit_sqcmp.sv -----
// ----------------------------------------------------------------------------
// Hitbox square and compare stages
// Squares the axis distances and the radius, then compares the distance
// sum with the squared radius and picks the final hit.
// ----------------------------------------------------------------------------
module hbit_sqcmp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbit_pkg::t_ctl       i_ctl,
    input  hbit_pkg::t_dst       i_dst,
    output logic                 o_valid,
    output logic                 o_hit
);
    import hbit_pkg::*;

    t_ctl r_ctl;
    t_sq  r_sqx, r_sqy;
    t_rsq r_rsq;
    t_sum n_sum;
    logic n_hit;
    logic r_valid, r_hit;

    // Square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.is_rr  <= i_ctl.is_rr;
        r_ctl.rr_hit <= i_ctl.rr_hit;
        r_sqx        <= i_dst.dx * i_dst.dx;
        r_sqy        <= i_dst.dy * i_dst.dy;
        r_rsq        <= i_dst.rad * i_dst.rad;
    end

    // Sum and compare; equal counts as a hit
    always_comb begin
        n_sum = t_sum'({1'b0, r_sqx}) + t_sum'({1'b0, r_sqy});
        n_hit = r_ctl.is_rr ? r_ctl.rr_hit
                            : (n_sum <= t_sum'({{(SUM_W-RSQ_W){1'b0}}, r_rsq}));
    end

    // Result register drives the strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl.valid;
        end
        r_hit <= n_hit;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

// ----- rtl/hitbox_intersection_test_core.sv -----
// ----------------------------------------------------------------------------
// Hitbox intersection test core
// Pipelined rectangle and circle pair collision test.
// ----------------------------------------------------------------------------
// One hitbox pair is taken on every clock edge at which start is high; busy
// stays low, so a new pair can follow in every cycle. The answer for a pair
// appears on o_hit with o_valid high for a single cycle, in the order the
// pairs came in. The four register stages are edge setup, clamp to the
// rectangle, squaring, and the final sum and compare; the first of them
// captures the pair at the edge that takes it. Touching shapes count as a
// hit.
module hitbox_intersection_test_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_shape_a,
    input  hbit_pkg::t_coord     i_ax,
    input  hbit_pkg::t_coord     i_ay,
    input  hbit_pkg::t_size      i_a_width,
    input  hbit_pkg::t_size      i_a_height,
    input  hbit_pkg::t_size      i_a_radius,
    input  logic                 i_shape_b,
    input  hbit_pkg::t_coord     i_bx,
    input  hbit_pkg::t_coord     i_by,
    input  hbit_pkg::t_size      i_b_width,
    input  hbit_pkg::t_size      i_b_height,
    input  hbit_pkg::t_size      i_b_radius,
    output logic                 o_valid,
    output logic                 o_hit
);
    import hbit_pkg::*;

    t_ctl s1_ctl, s2_ctl;
    t_geo s1_geo;
    t_dst s2_dst;

    // Pipeline never holds off a beat
    assign busy = 1'b0;

    hbit_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_shape_a  (i_shape_a),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_a_width  (i_a_width),
        .i_a_height (i_a_height),
        .i_a_radius (i_a_radius),
        .i_shape_b  (i_shape_b),
        .i_bx       (i_bx),
        .i_by       (i_by),
        .i_b_width  (i_b_width),
        .i_b_height (i_b_height),
        .i_b_radius (i_b_radius),
        .o_ctl      (s1_ctl),
        .o_geo      (s1_geo)
    );

    hbit_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_geo   (s1_geo),
        .o_ctl   (s2_ctl),
        .o_dst   (s2_dst)
    );

    hbit_sqcmp u_sqcmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s2_ctl),
        .i_dst   (s2_dst),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

endmodule
